### rtl/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while reset is held.
`define AST_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, clocked on i_clk, off while reset is held.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

### rtl/u16u8_pkg.sv
// Types, constants and the byte encoder shared by the UTF-16 to UTF-8 blocks.
package u16u8_pkg;

    localparam int CP_W       = 21;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    typedef enum logic [2:0] {
        K_ERR,
        K_ONE,
        K_TWO,
        K_THREE,
        K_FOUR
    } t_kind;

    typedef struct packed {
        t_kind           kind;
        logic [CP_W-1:0] cp;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_enc;

    // Byte number idx of the encoding of cp.
    function automatic t_enc f_enc(t_kind kind, logic [CP_W-1:0] cp, logic [1:0] idx);
        t_enc r;
        r.data = 8'h00;
        r.last = 1'b1;
        r.err  = 1'b0;
        unique case (kind)
            K_ERR: begin
                r.err = 1'b1;
            end
            K_ONE: begin
                r.data = {1'b0, cp[6:0]};
            end
            K_TWO: begin
                r.last = (idx == 2'd1);
                r.data = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            K_THREE: begin
                r.last = (idx == 2'd2);
                unique case (idx)
                    2'd0:    r.data = {4'b1110, cp[15:12]};
                    2'd1:    r.data = {2'b10, cp[11:6]};
                    default: r.data = {2'b10, cp[5:0]};
                endcase
            end
            K_FOUR: begin
                r.last = (idx == 2'd3);
                unique case (idx)
                    2'd0:    r.data = {5'b11110, cp[20:18]};
                    2'd1:    r.data = {2'b10, cp[17:12]};
                    2'd2:    r.data = {2'b10, cp[11:6]};
                    default: r.data = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                r.err = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder.
//
//  channel | dir | handshake         | beat payload
//  --------+-----+-------------------+-------------------------------------------
//  input   | in  | i_valid / o_stall | i_code_unit[15:0], i_end_of_string
//  output  | out | o_valid / i_stall | o_out_byte[7:0], o_last_byte, o_error
//
// One code unit is taken per cycle while the command queue has room.
// Each unit yields 0 to 4 output beats, one per cycle while i_stall is low;
// the byte sequencer in the back end sets the rate.
// Input to first output beat: the unit is queued, then loaded into the output register.
// Reset (i_rst_n low, synchronous) drops held surrogate, skip state,
// queued commands and the output register.
// o_stall follows queue full only; output stalls back up into the queue.
module utf16_to_utf8_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic        o_error
);
    import u16u8_pkg::*;

    `include "assert_macros.svh"

    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;
    t_cmd       w_head;
    t_fifo_stat w_fifo_stat;

    // classify units, pair surrogates, drop units after an error
    u16u8_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .i_fifo_stat     (w_fifo_stat),
        .o_push          (w_push),
        .o_cmd           (w_cmd)
    );

    // decouples unit intake from byte emission
    u16u8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_fifo_stat)
    );

    // walks each command out as 1 to 4 byte beats
    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_fifo_stat (w_fifo_stat),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_error     (o_error)
    );

    // front never pushes into a full queue
    `AST_NOW(a_no_push_full, w_push, !w_fifo_stat.full)
    // queue never reports full and empty together
    `AST_NOW(a_fifo_stat_sane, 1'b1, !(w_fifo_stat.full && w_fifo_stat.empty))
    // error beat stands alone and carries a zero byte
    `AST_NOW(a_err_beat, o_valid && o_error, o_last_byte && (o_out_byte == 8'h00))
    // non-final beats belong to a multi-byte sequence
    `AST_NOW(a_mid_beat, o_valid && !o_last_byte, o_out_byte[7] && !o_error)

endmodule

### rtl/u16u8_front.sv
// Front end: takes code units, tracks surrogate pairing and error skip, issues commands.
module u16u8_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_code_unit,
    input  logic                  i_end_of_string,
    input  u16u8_pkg::t_fifo_stat i_fifo_stat,
    output logic                  o_push,
    output u16u8_pkg::t_cmd       o_cmd
);
    import u16u8_pkg::*;

    logic       r_held_valid, n_held_valid;
    logic       r_halted, n_halted;
    logic [9:0] r_held_bits, n_held_bits;

    logic accept;
    logic is_high;
    logic is_low;

    assign o_stall = i_fifo_stat.full;
    assign accept  = i_valid && !i_fifo_stat.full;
    assign is_high = (i_code_unit[15:10] == HI_SURR_TAG);
    assign is_low  = (i_code_unit[15:10] == LO_SURR_TAG);

    always_comb begin
        n_held_valid = r_held_valid;
        n_halted     = r_halted;
        n_held_bits  = r_held_bits;
        o_push       = 1'b0;
        o_cmd.kind   = K_ERR;
        o_cmd.cp     = '0;
        if (accept) begin
            priority if (r_halted) begin
                // skipping after an error until the string ends
                if (i_end_of_string) begin
                    n_halted     = 1'b0;
                    n_held_valid = 1'b0;
                end
            end else if (r_held_valid) begin
                o_push       = 1'b1;
                n_held_valid = 1'b0;
                if (is_low) begin
                    o_cmd.kind = K_FOUR;
                    o_cmd.cp   = SUPP_BASE + {1'b0, r_held_bits, i_code_unit[9:0]};
                end else begin
                    n_halted = !i_end_of_string;
                end
            end else if (is_low) begin
                o_push   = 1'b1;
                n_halted = !i_end_of_string;
            end else if (is_high) begin
                if (i_end_of_string) begin
                    o_push   = 1'b1;
                end else begin
                    n_held_valid = 1'b1;
                    n_held_bits  = i_code_unit[9:0];
                end
            end else begin
                o_push   = 1'b1;
                o_cmd.cp = {5'd0, i_code_unit};
                priority if (i_code_unit[15:7] == '0) begin
                    o_cmd.kind = K_ONE;
                end else if (i_code_unit[15:11] == '0) begin
                    o_cmd.kind = K_TWO;
                end else begin
                    o_cmd.kind = K_THREE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_halted     <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_halted     <= n_halted;
        end
        r_held_bits <= n_held_bits;
    end

endmodule

### rtl/u16u8_fifo.sv
// Short command queue between front and back end.
module u16u8_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  u16u8_pkg::t_cmd       i_cmd,
    input  logic                  i_pop,
    output u16u8_pkg::t_cmd       o_head,
    output u16u8_pkg::t_fifo_stat o_stat
);
    import u16u8_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/u16u8_back.sv
// Back end: turns commands into UTF-8 byte beats behind an output register.
module u16u8_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  u16u8_pkg::t_cmd       i_head,
    input  u16u8_pkg::t_fifo_stat i_fifo_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_byte,
    output logic                  o_error
);
    import u16u8_pkg::*;

    logic       r_valid, n_valid;
    logic       r_busy, n_busy;
    t_cmd       r_cmd, n_cmd;
    logic [1:0] r_idx, n_idx;
    t_enc       r_out, n_out;

    logic       load;
    logic       have;
    t_cmd       cur;
    logic [1:0] cur_idx;
    t_enc       enc;

    assign load    = !r_valid || !i_stall;
    assign have    = r_busy || !i_fifo_stat.empty;
    assign cur     = r_busy ? r_cmd : i_head;
    assign cur_idx = r_busy ? r_idx : 2'd0;
    assign enc     = f_enc(cur.kind, cur.cp, cur_idx);
    assign o_pop   = load && !r_busy && !i_fifo_stat.empty;

    always_comb begin
        n_valid = r_valid;
        n_busy  = r_busy;
        n_cmd   = r_cmd;
        n_idx   = r_idx;
        n_out   = r_out;
        if (load) begin
            n_valid = have;
            if (have) begin
                n_out  = enc;
                n_busy = !enc.last;
                n_cmd  = cur;
                n_idx  = cur_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_busy  <= n_busy;
        end
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_out.data;
    assign o_last_byte = r_out.last;
    assign o_error     = r_out.err;

endmodule

### dv/utf16_to_utf8_encoder_tb.sv
// Self-checking testbench for the UTF-16 to UTF-8 encoder.
module utf16_to_utf8_encoder_tb;

    // One expected output beat.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_utf8_beat;

    // Tracks the surrogate/skip state of the encoder and queues the UTF-8
    // beats each accepted code unit must produce.
    class t_utf8_scoreboard;
        logic [9:0]  held_bits;
        bit          held;
        bit          halted;
        t_utf8_beat  expected_bytes[$];
        int          errors;
        int          units_used;

        function void push_beat(logic [7:0] data, logic last, logic err);
            t_utf8_beat b;
            b.data = data;
            b.last = last;
            b.err  = err;
            expected_bytes.insert(expected_bytes.size(), b);
        endfunction

        // Any surrogate violation: one stand-alone error beat, drop the held
        // half, and skip the rest of the string unless this unit ended it.
        function void push_error(logic eos);
            held      = 1'b0;
            held_bits = '0;
            halted    = !eos;
            push_beat(8'h00, 1'b1, 1'b1);
        endfunction

        function void encode_code_point(logic [20:0] cp);
            if (cp <= 21'h7F) begin
                push_beat(cp[7:0], 1'b1, 1'b0);
            end else if (cp <= 21'h7FF) begin
                push_beat({3'b110, cp[10:6]}, 1'b0, 1'b0);
                push_beat({2'b10, cp[5:0]}, 1'b1, 1'b0);
            end else if (cp <= 21'hFFFF) begin
                push_beat({4'b1110, cp[15:12]}, 1'b0, 1'b0);
                push_beat({2'b10, cp[11:6]}, 1'b0, 1'b0);
                push_beat({2'b10, cp[5:0]}, 1'b1, 1'b0);
            end else begin
                push_beat({5'b11110, cp[20:18]}, 1'b0, 1'b0);
                push_beat({2'b10, cp[17:12]}, 1'b0, 1'b0);
                push_beat({2'b10, cp[11:6]}, 1'b0, 1'b0);
                push_beat({2'b10, cp[5:0]}, 1'b1, 1'b0);
            end
        endfunction

        // Called for every accepted input beat.
        function void note_unit(logic [15:0] cu, logic eos);
            bit         is_high;
            bit         is_low;
            logic [20:0] cp;
            is_high = (cu[15:10] == 6'b110110);
            is_low  = (cu[15:10] == 6'b110111);
            units_used++;
            if (halted) begin
                // skipping after an error; end of string re-arms
                if (eos) begin
                    halted    = 1'b0;
                    held      = 1'b0;
                    held_bits = '0;
                end
                return;
            end
            if (held) begin
                if (!is_low) begin
                    push_error(eos);
                    return;
                end
                cp        = 21'h10000 + {1'b0, held_bits, cu[9:0]};
                held      = 1'b0;
                held_bits = '0;
                encode_code_point(cp);
                return;
            end
            if (is_low) begin
                push_error(eos);
                return;
            end
            if (is_high) begin
                if (eos) begin
                    push_error(eos);
                    return;
                end
                held_bits = cu[9:0];
                held      = 1'b1;
                return;
            end
            encode_code_point({5'b0, cu});
        endfunction

        // Called for every accepted output beat.
        function void check_beat(logic [7:0] data, logic last, logic err);
            t_utf8_beat exp_b;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual byte %h last %b err %b",
                         $time, data, last, err);
                errors++;
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (data !== exp_b.data) begin
                $display("%0t: out_byte mismatch, expected %h actual %h",
                         $time, exp_b.data, data);
                errors++;
            end
            if (last !== exp_b.last) begin
                $display("%0t: last_byte mismatch, expected %b actual %b",
                         $time, exp_b.last, last);
                errors++;
            end
            if (err !== exp_b.err) begin
                $display("%0t: error mismatch, expected %b actual %b",
                         $time, exp_b.err, err);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [15:0] i_code_unit     = '0;
    logic        i_end_of_string = 1'b0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic        o_error;

    t_utf8_scoreboard sb = new();

    // Calm flags switch off idling on one side for a stretch of stimulus.
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int rx_hold = 0;

    utf16_to_utf8_encoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_last_byte     (o_last_byte),
        .o_error         (o_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Idle cycles before a beat: none when calm or on a coin flip, else a random draw.
    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Monitor and output-side stall generator. Everything here samples the
    // pre-edge values, since all stimulus is driven with NBAs at the edge.
    // Output beats are checked before input beats are noted; no beat can
    // come out in the cycle its unit goes in.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_beat(o_out_byte, o_last_byte, o_error);
                rx_hold = draw_gap(rx_calm);
            end else if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
            end
            if (i_valid && !o_stall)
                sb.note_unit(i_code_unit, i_end_of_string);
        end
        i_stall <= (rx_hold != 0);
    end

    // One input beat: optional idle gap, then hold valid until taken.
    // Valid is only lowered when a gap is drawn, so it never gets two NBAs
    // in one step.
    task automatic send_unit(input logic [15:0] cu, input logic eos);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_code_unit     <= cu;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Sender holds off until every predicted beat has been seen.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_bytes.size() != 0);
    endtask

    // One string, mostly well-formed with random characters; now and then
    // a stray unit or a broken surrogate is mixed in.
    task automatic send_random_string();
        logic [15:0] units[$];
        int          n_chars;
        int          pick;
        bit          broken;
        broken  = ($urandom_range(0, 5) == 0);
        n_chars = $urandom_range(1, 6);
        for (int i = 0; i < n_chars; i++) begin
            pick = broken ? $urandom_range(0, 15) : $urandom_range(0, 13);
            case (pick)
                0, 1, 2, 3, 4:
                    units.insert(units.size(), 16'($urandom_range(16'h0000, 16'h007F)));
                5, 6, 7:
                    units.insert(units.size(), 16'($urandom_range(16'h0080, 16'h07FF)));
                8, 9:
                    units.insert(units.size(), 16'($urandom_range(16'h0800, 16'hD7FF)));
                10:
                    units.insert(units.size(), 16'($urandom_range(16'hE000, 16'hFFFF)));
                11, 12, 13: begin
                    units.insert(units.size(), 16'($urandom_range(16'hD800, 16'hDBFF)));
                    units.insert(units.size(), 16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
                14:
                    units.insert(units.size(), 16'($urandom_range(0, 16'hFFFF)));
                default: begin
                    if ($urandom_range(0, 1))
                        units.insert(units.size(), 16'($urandom_range(16'hDC00, 16'hDFFF)));
                    else
                        units.insert(units.size(), 16'($urandom_range(16'hD800, 16'hDBFF)));
                end
            endcase
        end
        foreach (units[i])
            send_unit(units[i], i == units.size() - 1);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: range edges of 1/2/3-byte forms, both 3-byte ranges
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // lowest and highest supplementary code points
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // lone low surrogate mid-string, rest of string skipped
        send_unit(16'hDC00, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0042, 1'b1);
        // unpaired high followed by a normal unit, then skip to end
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0043, 1'b1);
        // high surrogate carrying end of string
        send_unit(16'hDBFF, 1'b1);
        // held high followed by another high that ends the string
        send_unit(16'hD801, 1'b0);
        send_unit(16'hDB00, 1'b1);
        // lone low surrogate that ends the string: no skip afterwards
        send_unit(16'hDFFF, 1'b1);
        // pair whose low half ends the string
        send_unit(16'hD834, 1'b0);
        send_unit(16'hDD1E, 1'b1);

        wait_drained();

        // Random strings up to about 110 units in all; calm stretches on
        // either side now and then, and now and then a full drain partway through.
        while (sb.units_used < 110) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            send_random_string();
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_fifo.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_encoder.sv
dv/utf16_to_utf8_encoder_tb.sv
